// ===== design/s512c_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s512c_pkg
// Types, constants and sigma functions shared by the reduced-round
// SHA-512 compression block.
// ----------------------------------------------------------------------------
package s512c_pkg;

	localparam int WORD_W      = 64;
	localparam int NUM_VARS    = 8;
	localparam int WIN_DEPTH   = 16;
	localparam int WCNT_W      = 4;
	localparam int OCNT_W      = 3;
	localparam int CFG_IDX_W   = 4;
	localparam int CHAIN_IDX_W = 3;
	localparam int K_DEPTH     = 80;
	localparam int K_IDX_W     = 7;

	typedef logic [WORD_W-1:0] word_t;
	// index 0 is working variable a, index 7 is h
	typedef logic [NUM_VARS-1:0][WORD_W-1:0] vars_t;

	// initial hash value, reset value of the chaining registers
	localparam word_t CHAIN_IV [NUM_VARS] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	// round constants
	localparam word_t ROUND_K [K_DEPTH] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic word_t big_sig0(input word_t x);
		big_sig0 = {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
	endfunction

	function automatic word_t big_sig1(input word_t x);
		big_sig1 = {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
	endfunction

	function automatic word_t small_sig0(input word_t x);
		small_sig0 = {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
	endfunction

	function automatic word_t small_sig1(input word_t x);
		small_sig1 = {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
	endfunction

endpackage
`default_nettype wire

// ===== design/s512c_msg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s512c_msg_if
// Message word channel: one 64-bit message word per beat.
// ----------------------------------------------------------------------------
interface s512c_msg_if;
	logic        valid;
	logic        ready;
	logic [63:0] message_word;

	modport source (output valid, output message_word, input ready);
	modport sink (input valid, input message_word, output ready);
endinterface
`default_nettype wire

// ===== design/s512c_dig_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s512c_dig_if
// Digest channel: one digest word with its position per beat.
// ----------------------------------------------------------------------------
interface s512c_dig_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [2:0]  digest_index;
	logic        last_word;

	modport source (output valid, output digest_word, output digest_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input digest_index,
		input last_word, output ready);
endinterface
`default_nettype wire

// ===== design/s512c_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s512c_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface s512c_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [63:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/s512c_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// s512c_round
// One SHA-512 round: takes the working variables, the schedule word and the
// round constant and gives the working variables after the round.
// ----------------------------------------------------------------------------
module s512c_round import s512c_pkg::*; (
	input  vars_t cur,
	input  word_t w,
	input  word_t k,
	output vars_t nxt
);

	word_t ch;
	word_t maj;
	word_t t1;
	word_t t2;

	// choose and majority
	assign ch  = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
	assign maj = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);

	// the two temporaries, modulo 2^64
	assign t1 = cur[7] + big_sig1(cur[4]) + ch + k + w;
	assign t2 = big_sig0(cur[0]) + maj;

	// rotate the variables down by one place
	always_comb begin
		nxt[7] = cur[6];
		nxt[6] = cur[5];
		nxt[5] = cur[4];
		nxt[4] = cur[3] + t1;
		nxt[3] = cur[2];
		nxt[2] = cur[1];
		nxt[1] = cur[0];
		nxt[0] = t1 + t2;
	end

endmodule
`default_nettype wire

// ===== design/sha512_reduced_round_compression.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_reduced_round_compression
// Round-reduced SHA-512 compression with a fixed, configurable chaining value.
// ----------------------------------------------------------------------------
// Sixteen message words are taken one per beat on msg, one per cycle. On the
// sixteenth word the working variables load from the chaining registers and
// a single round unit runs ROUNDS rounds, one per cycle, extending the
// schedule in a 16-word shift window as it goes. Eight digest words then
// leave on dig, index 0 (word a) first, each the working variable plus its
// chaining word; last_word marks index 7. msg.ready is low from the
// sixteenth word until the eighth digest word sits in the output register.
// The output register takes one digest word per cycle while dig does not
// stall. The chaining registers (indexes 0 to 7 on cfg, reset to the
// SHA-512 initial hash value) are never updated by the block; writes to
// other indexes are dropped.
// ----------------------------------------------------------------------------
module sha512_reduced_round_compression import s512c_pkg::*; #(
	parameter int ROUNDS = 28
) (
	input  wire            clk,
	input  wire            arst_n,
	s512c_msg_if.sink      msg,
	s512c_dig_if.source    dig,
	s512c_cfg_if.sink      cfg
);

	localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_OUT   = 2'd2;

	typedef logic [WIN_DEPTH-1:0][WORD_W-1:0] window_t;

	logic [1:0]        state_q;
	logic [WCNT_W-1:0] wcnt_q;
	logic [RND_W-1:0]  rnd_q;
	logic [OCNT_W-1:0] ocnt_q;
	window_t           win_q;
	vars_t             vars_q;
	vars_t             vars_next;
	word_t             chain_q [NUM_VARS];
	word_t             sched_new;
	word_t             out_word_q;
	logic [OCNT_W-1:0] out_idx_q;
	logic              out_last_q;
	logic              out_valid_q;
	logic              in_beat;
	logic              out_load;
	logic              cfg_beat;

	assign in_beat  = msg.valid && msg.ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || dig.ready);
	assign cfg_beat = cfg.valid && cfg.ready;

	// handshake outputs
	assign msg.ready        = (state_q == ST_LOAD);
	assign cfg.ready        = 1'b1;
	assign dig.valid        = out_valid_q;
	assign dig.digest_word  = out_word_q;
	assign dig.digest_index = out_idx_q;
	assign dig.last_word    = out_last_q;

	// schedule extension from the window taps
	assign sched_new = small_sig1(win_q[14]) + win_q[9] + small_sig0(win_q[1]) + win_q[0];

	// shared round unit
	s512c_round u_round (
		.cur (vars_q),
		.w   (win_q[0]),
		.k   (ROUND_K[K_IDX_W'(rnd_q)]),
		.nxt (vars_next)
	);

	// chaining registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VARS; i++) chain_q[i] <= CHAIN_IV[i];
		end else if (cfg_beat && (cfg.index[CFG_IDX_W-1:CHAIN_IDX_W] == '0)) begin
			chain_q[cfg.index[CHAIN_IDX_W-1:0]] <= cfg.data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			wcnt_q      <= '0;
			rnd_q       <= '0;
			ocnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_beat) begin
						wcnt_q <= wcnt_q + 1'b1;
						if (wcnt_q == WCNT_W'(WIN_DEPTH - 1)) begin
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RND_W'(ROUNDS - 1)) begin
						ocnt_q  <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						ocnt_q <= ocnt_q + 1'b1;
						if (ocnt_q == OCNT_W'(NUM_VARS - 1)) state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase

			// output register valid
			if (out_load) out_valid_q <= 1'b1;
			else if (dig.ready) out_valid_q <= 1'b0;
		end
	end

	// window, working variables and output payload
	always_ff @(posedge clk) begin
		// message words shift in at the top of the window
		if (in_beat) begin
			for (int i = 0; i < WIN_DEPTH - 1; i++) win_q[i] <= win_q[i+1];
			win_q[WIN_DEPTH-1] <= msg.message_word;
		end

		// load from the chaining value on the last word of a block
		if (in_beat && (wcnt_q == WCNT_W'(WIN_DEPTH - 1))) begin
			for (int i = 0; i < NUM_VARS; i++) vars_q[i] <= chain_q[i];
		end

		// one round per cycle, schedule extended alongside
		if (state_q == ST_ROUND) begin
			vars_q <= vars_next;
			for (int i = 0; i < WIN_DEPTH - 1; i++) win_q[i] <= win_q[i+1];
			win_q[WIN_DEPTH-1] <= sched_new;
		end

		// feed-forward of word a, then shift the next variable down
		if (out_load) begin
			out_word_q <= vars_q[0] + chain_q[ocnt_q];
			out_idx_q  <= ocnt_q;
			out_last_q <= (ocnt_q == OCNT_W'(NUM_VARS - 1));
			for (int i = 0; i < NUM_VARS - 1; i++) vars_q[i] <= vars_q[i+1];
		end
	end

	// sixteenth word of a block starts the rounds
	assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && (wcnt_q == WCNT_W'(WIN_DEPTH - 1)) |=> (state_q == ST_ROUND))
		else $error("rounds did not start after the sixteenth word");

	// round counter stays within the configured round count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> ({1'b0, rnd_q} < (RND_W + 1)'(ROUNDS)))
		else $error("round counter ran past the last round");

	// word counter has wrapped while digest words go out
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (wcnt_q == '0))
		else $error("word counter not wrapped during output");

	// last_word marks exactly the eighth digest word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_last_q == (out_idx_q == OCNT_W'(NUM_VARS - 1))))
		else $error("last_word does not match digest index");

endmodule
`default_nettype wire

// ===== tb/sha512_reduced_round_compression_test.sv =====
// ----------------------------------------------------------------------------
// sha512_reduced_round_compression_test
// Self-checking bench for the round-reduced SHA-512 compression block. Words
// go in one beat at a time with random gaps. An in-bench model of the rounds
// and the chaining registers predicts each digest beat, and every digest beat
// is checked field by field as it leaves. Chaining values move between the
// reset value, all zeros, all ones and random words, and writes to unused
// register indexes must leave them alone.
// ----------------------------------------------------------------------------
module sha512_reduced_round_compression_test import s512c_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROUNDS = 28;
	localparam int CFG_INDEX_SPAN = 1 << CFG_IDX_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CHAIN_0_REG, CHAIN_1_REG, CHAIN_2_REG, CHAIN_3_REG,
		CHAIN_4_REG, CHAIN_5_REG, CHAIN_6_REG, CHAIN_7_REG
	} chain_reg_t;

	typedef struct {
		word_t                word;
		logic [OCNT_W-1:0]    index;
		logic                 last;
	} digest_beat_t;

	// round constants, first 64 bits of the fractional cube roots of the primes
	localparam word_t K_SHA512 [K_DEPTH] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	// standard initial hash value, the chaining registers after reset
	localparam word_t CHAIN_RESET_VAL [NUM_VARS] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	logic clk;
	logic arst_n;

	s512c_msg_if msg_if();
	s512c_dig_if dig_if();
	s512c_cfg_if cfg_if();

	sha512_reduced_round_compression #(
		.ROUNDS (ROUNDS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.dig    (dig_if),
		.cfg    (cfg_if)
	);

	// bench copy of the block state
	word_t                chain_reg [NUM_VARS];
	word_t                sched_window [WIN_DEPTH];
	logic [WCNT_W-1:0]    words_held;
	digest_beat_t         expected_digest_q [$];

	bit stall_enable = 1'b1;
	int fail_count = 0;

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// sigma mixing, written out from the rotation amounts
	function automatic word_t rotr64(input word_t x, input int n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t upper_sum0(input word_t x);
		return rotr64(x, 28) ^ rotr64(x, 34) ^ rotr64(x, 39);
	endfunction

	function automatic word_t upper_sum1(input word_t x);
		return rotr64(x, 14) ^ rotr64(x, 18) ^ rotr64(x, 41);
	endfunction

	function automatic word_t sched_mix0(input word_t x);
		return rotr64(x, 1) ^ rotr64(x, 8) ^ (x >> 7);
	endfunction

	function automatic word_t sched_mix1(input word_t x);
		return rotr64(x, 19) ^ rotr64(x, 61) ^ (x >> 6);
	endfunction

	// run the rounds on a full window and queue the eight digest beats
	function automatic void compress_block();
		word_t v [NUM_VARS];
		word_t w;
		word_t t1;
		word_t t2;
		digest_beat_t beat;
		for (int i = 0; i < NUM_VARS; i++)
			v[i] = chain_reg[i];
		for (int t = 0; t < ROUNDS && t < K_DEPTH; t++) begin
			if (t >= WIN_DEPTH) begin
				sched_window[t % WIN_DEPTH] = sched_mix1(sched_window[(t - 2) % WIN_DEPTH])
					+ sched_window[(t - 7) % WIN_DEPTH]
					+ sched_mix0(sched_window[(t - 15) % WIN_DEPTH])
					+ sched_window[t % WIN_DEPTH];
			end
			w = sched_window[t % WIN_DEPTH];
			t1 = v[7] + upper_sum1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_SHA512[t] + w;
			t2 = upper_sum0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < NUM_VARS; i++) begin
			beat.word = v[i] + chain_reg[i];
			beat.index = OCNT_W'(i);
			beat.last = (i == NUM_VARS - 1);
			expected_digest_q.insert(expected_digest_q.size(), beat);
		end
	endfunction

	// mostly random words, now and then all zeros or all ones
	function automatic word_t rand_word();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// one message beat, with a random gap in front
	task automatic send_word(input word_t w);
		int gap;
		gap = stall_enable ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			msg_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_if.valid <= 1'b1;
		msg_if.message_word <= w;
		do @(posedge clk); while (!msg_if.ready);
		sched_window[words_held] = w;
		words_held = words_held + 1'b1;
		if (words_held == '0)
			compress_block();
	endtask

	// one register write beat
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		if (idx <= CHAIN_7_REG)
			chain_reg[idx[CHAIN_IDX_W-1:0]] = value;
		@(posedge clk);
	endtask

	task automatic load_chain(input word_t vals [NUM_VARS]);
		for (int i = 0; i < NUM_VARS; i++)
			write_reg(CFG_IDX_W'(int'(CHAIN_0_REG) + i), vals[i]);
	endtask

	// stop sending, let every digest beat out and give the rounds time to finish
	task automatic wait_idle();
		msg_if.valid <= 1'b0;
		wait (expected_digest_q.size() == 0);
		repeat (ROUNDS + WIN_DEPTH) @(posedge clk);
	endtask

	task automatic send_random_block();
		for (int i = 0; i < WIN_DEPTH; i++)
			send_word(rand_word());
	endtask

	// field extremes and alternating patterns under the reset chaining value
	task automatic test_directed_extremes();
		word_t pattern [WIN_DEPTH];
		pattern = '{
			64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
			64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
			64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
			64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_fffe,
			64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000,
			64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
			64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
			64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0001
		};
		foreach (pattern[i])
			send_word(pattern[i]);
		wait_idle();
	endtask

	// writes past the last chaining register must be dropped
	task automatic test_unknown_index();
		for (int i = int'(CHAIN_7_REG) + 1; i < CFG_INDEX_SPAN; i++)
			write_reg(CFG_IDX_W'(i), rand_word());
		send_random_block();
		wait_idle();
	endtask

	task automatic test_chain_extremes();
		word_t vals [NUM_VARS];
		foreach (vals[i])
			vals[i] = '0;
		load_chain(vals);
		send_random_block();
		wait_idle();
		foreach (vals[i])
			vals[i] = '1;
		load_chain(vals);
		send_random_block();
		wait_idle();
	endtask

	task automatic test_random_chain();
		word_t vals [NUM_VARS];
		repeat (4) begin
			foreach (vals[i])
				vals[i] = {$urandom, $urandom};
			load_chain(vals);
			send_random_block();
			wait_idle();
		end
	endtask

	// back-to-back beats on both channels
	task automatic test_no_stall();
		stall_enable = 1'b0;
		repeat (3)
			send_random_block();
		wait_idle();
		stall_enable = 1'b1;
	endtask

	// long stream, with one hold-off part way into a block
	task automatic test_random_stream();
		for (int n = 0; n < 7 * WIN_DEPTH; n++) begin
			if (n == 3 * WIN_DEPTH + 5)
				wait_idle();
			send_word(rand_word());
		end
		wait_idle();
	endtask

	// digest sink: random stalls, every beat checked against the oldest prediction
	initial begin : digest_checker
		int stall;
		digest_beat_t want;
		dig_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = stall_enable ? $urandom_range(0, 7) : 0;
			if (stall > 0) begin
				dig_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dig_if.ready <= 1'b1;
			do @(posedge clk); while (!dig_if.valid);
			if (expected_digest_q.size() == 0) begin
				$error("unexpected digest beat: digest_word %h digest_index %0d last_word %b",
					dig_if.digest_word, dig_if.digest_index, dig_if.last_word);
				fail_count++;
			end else begin
				want = expected_digest_q.pop_front();
				if (dig_if.digest_word !== want.word) begin
					$error("digest_word: expected %h, actual %h", want.word, dig_if.digest_word);
					fail_count++;
				end
				if (dig_if.digest_index !== want.index) begin
					$error("digest_index: expected %0d, actual %0d", want.index,
						dig_if.digest_index);
					fail_count++;
				end
				if (dig_if.last_word !== want.last) begin
					$error("last_word: expected %b, actual %b", want.last, dig_if.last_word);
					fail_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("FAIL sha512_reduced_round_compression");
		$finish;
	end

	// reset, then the tests in turn
	initial begin
		arst_n <= 1'b0;
		msg_if.valid <= 1'b0;
		msg_if.message_word <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= '0;
		cfg_if.data <= '0;
		chain_reg = CHAIN_RESET_VAL;
		words_held = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_unknown_index();
		test_chain_extremes();
		test_random_chain();
		test_no_stall();
		test_random_stream();

		if (fail_count == 0)
			$display("PASS sha512_reduced_round_compression");
		else
			$display("FAIL sha512_reduced_round_compression");
		$finish;
	end

endmodule

// ===== files.f =====
design/s512c_pkg.sv
design/s512c_msg_if.sv
design/s512c_dig_if.sv
design/s512c_cfg_if.sv
design/s512c_round.sv
design/sha512_reduced_round_compression.sv
tb/sha512_reduced_round_compression_test.sv
